// ===== src/fsd_pkg.sv =====
package fsd_pkg;

  localparam int DEF_MAX_WIDTH  = 320;
  localparam int DEF_MAX_HEIGHT = 240;
  localparam int DEF_ERR_FRAC   = 4;

  localparam int PIX_W        = 8;
  localparam int COLOR_W      = 3;
  localparam int FB_ADDR_W    = 17;
  localparam int IN_DATA_W    = 24;
  localparam int OUT_DATA_W   = 24;
  localparam int CFG_WIDTH_W  = 9;
  localparam int CFG_HEIGHT_W = 8;
  localparam int CFG_DATA_W   = 9;
  localparam int CFG_ADDR_W   = 1;

  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CFG_WIDTH_W-1:0]  RST_IMAGE_WIDTH  = 9'd320;
  localparam logic [CFG_HEIGHT_W-1:0] RST_IMAGE_HEIGHT = 8'd240;

  typedef struct packed {
    logic last_col;
    logic last_row;
    logic have_above;
  } pos_flags_t;

endpackage

// ===== src/fsd_ram.sv =====
module fsd_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 320
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/fsd_pos.sv =====
module fsd_pos import fsd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [CFG_WIDTH_W-1:0]        image_width,
  input  logic [CFG_HEIGHT_W-1:0]       image_height,
  output logic [$clog2(MAX_WIDTH)-1:0]  col,
  output logic [$clog2(MAX_HEIGHT)-1:0] row,
  output pos_flags_t                    flags
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int CWX   = (COL_W > CFG_WIDTH_W) ? COL_W : CFG_WIDTH_W;
  localparam int RWX   = (ROW_W > CFG_HEIGHT_W) ? ROW_W : CFG_HEIGHT_W;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CWX-1:0]   wlim;
  logic [RWX-1:0]   hlim;

  // last column / last row index, zero size acts as one, clamped to the maximum
  always_comb begin
    if (image_width == '0) begin
      wlim = '0;
    end else begin
      wlim = CWX'(image_width) - CWX'(1);
    end
    if (wlim > CWX'(MAX_WIDTH - 1)) begin
      wlim = CWX'(MAX_WIDTH - 1);
    end
    if (image_height == '0) begin
      hlim = '0;
    end else begin
      hlim = RWX'(image_height) - RWX'(1);
    end
    if (hlim > RWX'(MAX_HEIGHT - 1)) begin
      hlim = RWX'(MAX_HEIGHT - 1);
    end
  end

  assign flags.last_col   = CWX'(col_r) >= wlim;
  assign flags.last_row   = RWX'(row_r) >= hlim;
  assign flags.have_above = row_r != '0;
  assign col = col_r;
  assign row = row_r;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (step) begin
      if (flags.last_col) begin
        col_nxt = '0;
        row_nxt = flags.last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

`ifndef SYNTH
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= COL_W'(MAX_WIDTH - 1))
    else $error("column count out of range");
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= ROW_W'(MAX_HEIGHT - 1))
    else $error("row count out of range");
`endif

endmodule

// ===== src/fsd_diffuse.sv =====
module fsd_diffuse import fsd_pkg::*; #(
  parameter int MAX_WIDTH           = DEF_MAX_WIDTH,
  parameter int ERROR_FRACTION_BITS = DEF_ERR_FRAC
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   commit,
  input  logic [2:0][PIX_W-1:0]                  pix,
  input  logic [$clog2(MAX_WIDTH)-1:0]           col,
  input  pos_flags_t                             flags,
  input  logic [3*(ERROR_FRACTION_BITS+10)-1:0]  above,
  output logic [COLOR_W-1:0]                     color,
  output logic                                   mem_we,
  output logic [$clog2(MAX_WIDTH)-1:0]           mem_waddr,
  output logic [3*(ERROR_FRACTION_BITS+10)-1:0]  mem_wdata
);

  localparam int CHAN  = ERROR_FRACTION_BITS + 10;
  localparam int WORD  = 3 * CHAN;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam logic signed [CHAN-1:0] HALF_V = CHAN'(255 << (ERROR_FRACTION_BITS - 1));
  localparam logic signed [CHAN:0]   FULL_X = (CHAN + 1)'(255 << ERROR_FRACTION_BITS);

  function automatic logic signed [CHAN-1:0] sat_f(input logic signed [CHAN:0] v);
    if (v[CHAN] != v[CHAN-1]) begin
      sat_f = v[CHAN] ? {1'b1, {(CHAN-1){1'b0}}} : {1'b0, {(CHAN-1){1'b1}}};
    end else begin
      sat_f = v[CHAN-1:0];
    end
  endfunction

  function automatic logic signed [CHAN-1:0] add_f(input logic signed [CHAN-1:0] a,
                                                    input logic signed [CHAN-1:0] b);
    add_f = sat_f({a[CHAN-1], a} + {b[CHAN-1], b});
  endfunction

  // (e * k) >> 4 with floor rounding
  function automatic logic signed [CHAN-1:0] weigh_f(input logic signed [CHAN-1:0] e,
                                                      input logic [2:0] k);
    logic signed [CHAN+3:0] p;
    p = (CHAN + 4)'(e) * signed'({1'b0, k});
    weigh_f = p[CHAN+3:4];
  endfunction

  logic signed [CHAN-1:0] carry_r [3];
  logic signed [CHAN-1:0] bp0_r [3];
  logic signed [CHAN-1:0] bp1_r [3];
  logic signed [CHAN-1:0] w7 [3];
  logic signed [CHAN-1:0] w1 [3];
  logic signed [CHAN-1:0] dir_v [3];
  logic signed [CHAN-1:0] nb1_v [3];
  logic [2:0]             bits;
  logic [WORD-1:0]        dir_word, nb1_word;
  logic                   pend_valid_r;
  logic [COL_W-1:0]       pend_addr_r;
  logic [WORD-1:0]        pend_data_r;

  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic signed [CHAN-1:0] pix_v, abv, v0, v1, err, w3, w5;
    assign pix_v = signed'(CHAN'({pix[c], {ERROR_FRACTION_BITS{1'b0}}}));
    assign abv   = signed'(above[c*CHAN +: CHAN]);
    assign v0    = add_f(pix_v, carry_r[c]);
    assign v1    = flags.have_above ? add_f(v0, abv) : v0;
    assign bits[2-c] = v1 >= HALF_V;
    assign err   = (v1 >= HALF_V) ? sat_f({v1[CHAN-1], v1} - FULL_X) : v1;
    assign w7[c] = weigh_f(err, 3'd7);
    assign w3    = weigh_f(err, 3'd3);
    assign w5    = weigh_f(err, 3'd5);
    assign w1[c] = weigh_f(err, 3'd1);
    assign dir_v[c] = add_f(bp0_r[c], w3);
    assign nb1_v[c] = add_f(bp1_r[c], w5);
  end

  assign color    = bits;
  assign dir_word = {dir_v[2], dir_v[1], dir_v[0]};
  assign nb1_word = {nb1_v[2], nb1_v[1], nb1_v[0]};

  // a last column past column 0 needs two writes: the second is written in the following cycle,
  // when the next item is column 0 and writes nothing
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = col;
    mem_wdata = dir_word;
    if (pend_valid_r) begin
      mem_we    = 1'b1;
      mem_waddr = pend_addr_r;
      mem_wdata = pend_data_r;
    end else if (commit && col != '0) begin
      mem_we    = 1'b1;
      mem_waddr = col - COL_W'(1);
    end else if (commit && flags.last_col) begin
      mem_we    = 1'b1;
      mem_wdata = nb1_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        carry_r[c] <= '0;
        bp0_r[c]   <= '0;
        bp1_r[c]   <= '0;
      end
    end else begin
      pend_valid_r <= commit && flags.last_col && col != '0;
      if (commit) begin
        for (int c = 0; c < 3; c++) begin
          if (flags.last_col) begin
            carry_r[c] <= '0;
            bp0_r[c]   <= '0;
            bp1_r[c]   <= '0;
          end else begin
            carry_r[c] <= w7[c];
            bp0_r[c]   <= nb1_v[c];
            bp1_r[c]   <= w1[c];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      pend_addr_r <= col;
      pend_data_r <= nb1_word;
    end
  end

`ifndef SYNTH
  a_pend_single: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |=> !pend_valid_r)
    else $error("deferred write pending two cycles in a row");
  a_carry_clear: assert property (@(posedge clk) disable iff (!rst_n)
    commit && flags.last_col |=>
      carry_r[0] == '0 && carry_r[1] == '0 && carry_r[2] == '0)
    else $error("right carry not cleared at end of row");
`endif

endmodule

// ===== src/floyd_steinberg_rgb_dither.sv =====
// Floyd-Steinberg dither of an RGB pixel stream to a 3-bit color. Pixels come in
// raster order for an image of image_width by image_height (zero acts as one,
// values above MAX_WIDTH / MAX_HEIGHT are clamped); each item gives its color,
// its framebuffer address row * MAX_WIDTH + column and tlast on the last pixel
// of the frame. One pixel per clock sustained unless out_tready stalls the output.
// The input stage reads the error row buffer (single-port write, registered read),
// the output stage thresholds and spreads the error. The end-of-row write to the
// buffer uses the following cycle. Write image_width / image_height only while the
// block is idle; the frame position restarts only at the end of a frame or on reset.
module floyd_steinberg_rgb_dither import fsd_pkg::*; #(
  parameter int MAX_WIDTH           = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT          = DEF_MAX_HEIGHT,
  parameter int ERROR_FRACTION_BITS = DEF_ERR_FRAC
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // red_in, green_in, blue_in
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // color_code, fb_address, zero fill
  output logic                  out_tlast,  // frame_done
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CHAN  = ERROR_FRACTION_BITS + 10;
  localparam int WORD  = 3 * CHAN;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int PW    = ROW_W + COL_W + 1;

  logic [CFG_WIDTH_W-1:0]  width_r;
  logic [CFG_HEIGHT_W-1:0] height_r;

  logic             in_acc, adv, commit;
  logic [COL_W-1:0] pos_col;
  logic [ROW_W-1:0] pos_row;
  pos_flags_t       pos_flags;

  logic                   s1_valid_r;
  logic [2:0][PIX_W-1:0]  s1_pix_r;
  logic [COL_W-1:0]       s1_col_r;
  logic [ROW_W-1:0]       s1_row_r;
  pos_flags_t             s1_flags_r;

  logic             mem_we;
  logic [COL_W-1:0] mem_waddr;
  logic [WORD-1:0]  mem_wdata, ram_rdata, above;
  logic             byp_hit_r;
  logic [WORD-1:0]  byp_data_r;

  logic [COLOR_W-1:0]   color;
  logic [PW-1:0]        lin_addr;
  logic                 out_valid_r;
  logic [COLOR_W-1:0]   out_color_r;
  logic [FB_ADDR_W-1:0] out_addr_r;
  logic                 out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_IMAGE_WIDTH;
      height_r <= RST_IMAGE_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata[CFG_WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_wdata[CFG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;
  assign commit    = s1_valid_r && adv;

  fsd_pos #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pos (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (in_acc),
    .image_width  (width_r),
    .image_height (height_r),
    .col          (pos_col),
    .row          (pos_row),
    .flags        (pos_flags)
  );

  fsd_ram #(
    .WIDTH (WORD),
    .DEPTH (MAX_WIDTH)
  ) u_row_buf (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (in_acc),
    .raddr (pos_col),
    .rdata (ram_rdata)
  );

  // forward a write that lands in the same cycle as the read
  always_ff @(posedge clk) begin
    if (in_acc) begin
      byp_hit_r  <= mem_we && mem_waddr == pos_col;
      byp_data_r <= mem_wdata;
    end
  end

  assign above = byp_hit_r ? byp_data_r : ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r   <= in_tdata[3*PIX_W-1:0];
      s1_col_r   <= pos_col;
      s1_row_r   <= pos_row;
      s1_flags_r <= pos_flags;
    end
  end

  fsd_diffuse #(
    .MAX_WIDTH           (MAX_WIDTH),
    .ERROR_FRACTION_BITS (ERROR_FRACTION_BITS)
  ) u_diffuse (
    .clk       (clk),
    .rst_n     (rst_n),
    .commit    (commit),
    .pix       (s1_pix_r),
    .col       (s1_col_r),
    .flags     (s1_flags_r),
    .above     (above),
    .color     (color),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata)
  );

  assign lin_addr = PW'(s1_row_r) * PW'(MAX_WIDTH) + PW'(s1_col_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_color_r <= color;
      out_addr_r  <= FB_ADDR_W'(lin_addr);
      out_last_r  <= s1_flags_r.last_col && s1_flags_r.last_row;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - FB_ADDR_W - COLOR_W)'(0), out_addr_r, out_color_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_tready |-> !in_tready)
    else $error("input taken while pipeline is full");
  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("committed item did not reach the output");
`endif

endmodule
